// ----- design/rbh_pkg.sv -----
// Package: shared widths and types for the ray/box hit test.
`default_nettype none
package rbh_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  // Result queue depth: enough credit to keep ready high at full rate.
  localparam int unsigned StallDepth = 5;

  typedef struct packed {
    logic signed [CoordW-1:0] ray_origin_x;
    logic signed [CoordW-1:0] ray_origin_y;
    logic signed [CoordW-1:0] ray_origin_z;
    logic signed [CoordW-1:0] ray_dir_x;
    logic signed [CoordW-1:0] ray_dir_y;
    logic signed [CoordW-1:0] ray_dir_z;
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
  } query_t;

  // Per-axis operands after the subtract stage.
  typedef struct packed {
    logic signed [DiffW-1:0] d;   // direction
    logic signed [DiffW-1:0] lo;  // lo - o
    logic signed [DiffW-1:0] hi;  // hi - o
  } axis_t;
endpackage
`default_nettype wire

// ----- design/rbh_if.sv -----
// Interfaces: query and result channels.
`default_nettype none
interface rbh_query_if;
  import rbh_pkg::*;
  logic   valid;
  logic   ready;
  query_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbh_result_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface
`default_nettype wire

// ----- design/rbh_face.sv -----
// Face test: products of one face, registered, then the compare.
`default_nettype none
module rbh_face (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic                        upper,
  input  wire rbh_pkg::axis_t              a,   // face axis
  input  wire rbh_pkg::axis_t              b,   // other axis 1
  input  wire rbh_pkg::axis_t              c,   // other axis 2
  output logic                             hit
);
  import rbh_pkg::*;
  logic signed [DiffW-1:0] num, den;
  logic                    live;
  logic signed [ProdW-1:0] pb, lb, hb, pc, lc, hc;
  logic                    live_q;

  always_comb begin
    if (upper) begin
      num  = -a.hi;
      den  = -a.d;
      live = a.d < 0;
    end else begin
      num  = a.lo;
      den  = a.d;
      live = a.d > 0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      live_q <= live && (num >= 0);
      pb <= ProdW'(b.d) * ProdW'(num);
      lb <= ProdW'(b.lo) * ProdW'(den);
      hb <= ProdW'(b.hi) * ProdW'(den);
      pc <= ProdW'(c.d) * ProdW'(num);
      lc <= ProdW'(c.lo) * ProdW'(den);
      hc <= ProdW'(c.hi) * ProdW'(den);
    end
  end

  assign hit = live_q && (lb <= pb) && (pb <= hb) && (lc <= pc) && (pc <= hc);
endmodule
`default_nettype wire

// ----- design/ray_box_hit_test.sv -----
// Top level: pipelined ray versus axis-aligned box hit test.
// Channels: query (sink) carries origin, direction and box corners, signed
// Q16.16; result (source) carries one hit bit per query, in order.
// Pipeline: stage 1 subtracts origin from corners, stage 2 holds the six
// faces' 33x33 products, stage 3 registers the OR of the six face compares.
// Result path: a result passes stages 1 to 3 and is then pushed into the skid
// queue, whose registered count raises result valid.
// Throughput: one query per cycle while credit remains, set by the fully pipelined product stage.
// Stall: the pipe runs freely; a five-entry skid queue after stage 3 holds
// results while the receiver stalls. Ready comes from a credit count of
// queued plus in-flight items and drops only when five are outstanding.
// Reset clears valid bits and the skid queue; data registers are not reset.
`default_nettype none
module ray_box_hit_test (
  input wire logic   clk,
  input wire logic   rst,
  rbh_query_if.sink  query,
  rbh_result_if.source result
);
  import rbh_pkg::*;
  localparam int unsigned Stages = 3;
  localparam int unsigned CntW = $clog2(StallDepth + 1);
  localparam int unsigned QIdxW = $clog2(StallDepth);

  axis_t ax [3];
  logic  [Stages-1:0] v;
  logic  [5:0]        fh;
  logic               hit3;
  logic  [StallDepth-1:0] qh;
  logic  [CntW-1:0]   cnt;   // results queued plus items in flight
  logic               push, pop;

  // Ready from occupancy: credit covers everything that may still arrive.
  assign query.ready = cnt < CntW'(StallDepth);
  wire take = query.valid && query.ready;
  wire en = 1'b1;

  always_ff @(posedge clk) begin
    ax[0] <= '{DiffW'(query.data.ray_dir_x),
               DiffW'(query.data.box_min_x) - DiffW'(query.data.ray_origin_x),
               DiffW'(query.data.box_max_x) - DiffW'(query.data.ray_origin_x)};
    ax[1] <= '{DiffW'(query.data.ray_dir_y),
               DiffW'(query.data.box_min_y) - DiffW'(query.data.ray_origin_y),
               DiffW'(query.data.box_max_y) - DiffW'(query.data.ray_origin_y)};
    ax[2] <= '{DiffW'(query.data.ray_dir_z),
               DiffW'(query.data.box_min_z) - DiffW'(query.data.ray_origin_z),
               DiffW'(query.data.box_max_z) - DiffW'(query.data.ray_origin_z)};
    hit3 <= |fh;
  end

  rbh_face u_f0 (.clk, .en, .upper(1'b0), .a(ax[0]), .b(ax[1]), .c(ax[2]), .hit(fh[0]));
  rbh_face u_f1 (.clk, .en, .upper(1'b1), .a(ax[0]), .b(ax[1]), .c(ax[2]), .hit(fh[1]));
  rbh_face u_f2 (.clk, .en, .upper(1'b0), .a(ax[1]), .b(ax[0]), .c(ax[2]), .hit(fh[2]));
  rbh_face u_f3 (.clk, .en, .upper(1'b1), .a(ax[1]), .b(ax[0]), .c(ax[2]), .hit(fh[3]));
  rbh_face u_f4 (.clk, .en, .upper(1'b0), .a(ax[2]), .b(ax[0]), .c(ax[1]), .hit(fh[4]));
  rbh_face u_f5 (.clk, .en, .upper(1'b1), .a(ax[2]), .b(ax[0]), .c(ax[1]), .hit(fh[5]));

  // Skid queue fed by the free-running pipe.
  logic [CntW-1:0]       qn;    // entries held in the queue
  logic [StallDepth-1:0] qh_next;
  logic [QIdxW-1:0]      wr_idx;
  assign push = v[Stages-1];
  assign pop  = result.valid && result.ready;
  assign result.valid = qn != '0;
  assign result.hit   = qh[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      cnt <= '0;
      qn  <= '0;
    end else begin
      v   <= {v[Stages-2:0], take};
      cnt <= cnt + CntW'(take) - CntW'(pop);
      qn  <= qn + CntW'(push) - CntW'(pop);
    end
  end

  // Head at entry 0; a push lands just behind the entries that remain.
  always_comb begin
    wr_idx  = QIdxW'(qn - CntW'(pop));
    qh_next = qh;
    if (pop) qh_next = {1'b0, qh[StallDepth-1:1]};
    if (push) qh_next[wr_idx] = hit3;
  end

  always_ff @(posedge clk) begin
    qh <= qh_next;
  end
endmodule
`default_nettype wire

// ----- design/rbh_checker.sv -----
// Checker on the top-level ports, bound to the top level.
`default_nettype none
module rbh_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  input wire logic q_ready,
  input wire logic r_valid,
  input wire logic r_ready,
  input wire logic r_hit
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_hit)) else $error("result dropped");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> ##4 r_valid) else $error("result late");
  a_rst: assert property (@(posedge clk) rst |=> !r_valid) else $error("valid after reset");
endmodule

bind ray_box_hit_test rbh_checker u_chk (.clk(clk), .rst(rst),
  .q_valid(query.valid), .q_ready(query.ready),
  .r_valid(result.valid), .r_ready(result.ready), .r_hit(result.hit));
`default_nettype wire
